// ===== hdl/lsha_pkg.sv =====
// Shared SHA-256 constants and round helper functions for the set-hash accumulator.
`default_nettype none
package lsha_pkg;

   typedef logic [31:0] word_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [7:0] BYTE_MASK = 8'hff;

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type sml_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type sml_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/lsha_core.sv =====
// Iterative SHA-256 compression unit: one round per cycle.
`default_nettype none
module lsha_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [511:0] block,
   input  wire logic [255:0] chain_in,
   output logic              done,
   output logic [255:0]      chain_sum
);
   import lsha_pkg::*;

   word_type st_ff [8];
   word_type st_in [8];
   word_type w_ff  [16];
   word_type w_in  [16];
   logic [5:0] rnd_ff, rnd_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;

   word_type t1, t2, w_new;

   always_comb begin
      t1 = st_ff[7] + big_sig1(st_ff[4]) + ((st_ff[4] & st_ff[5]) ^ (~st_ff[4] & st_ff[6]))
         + SHA_K[rnd_ff] + w_ff[0];
      t2 = big_sig0(st_ff[0])
         + ((st_ff[0] & st_ff[1]) ^ (st_ff[0] & st_ff[2]) ^ (st_ff[1] & st_ff[2]));
      w_new = sml_sig1(w_ff[14]) + w_ff[9] + sml_sig0(w_ff[1]) + w_ff[0];
      st_in   = st_ff;
      w_in    = w_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // load working variables and the message words
         for (int i = 0; i < 8; i++) begin
            st_in[i] = chain_in[255 - 32*i -: 32];
         end
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block[511 - 32*i -: 32];
         end
         rnd_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         st_in[0] = t1 + t2;
         st_in[1] = st_ff[0];
         st_in[2] = st_ff[1];
         st_in[3] = st_ff[2];
         st_in[4] = st_ff[3] + t1;
         st_in[5] = st_ff[4];
         st_in[6] = st_ff[5];
         st_in[7] = st_ff[6];
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = w_new;
         rnd_in   = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      w_ff   <= w_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_sum[255 - 32*i -: 32] = chain_in[255 - 32*i -: 32] + st_ff[i];
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/lsha_hasher.sv =====
// Byte-stream SHA-256 hasher with padding sequencer; returns to the initial state after each digest.
`default_nettype none
module lsha_hasher (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   byte_valid,
   input  wire logic [7:0] byte_data,
   input  wire logic   finish,
   output logic        byte_ready,
   output logic        done,
   output logic [255:0] digest
);
   import lsha_pkg::*;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_COMP = 3'd1;
   localparam logic [2:0] H_P80  = 3'd2;
   localparam logic [2:0] H_PZ   = 3'd3;
   localparam logic [2:0] H_LEN  = 3'd4;
   localparam logic [2:0] H_DONE = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [2:0]   ret_ff, ret_in;
   logic [511:0] buf_ff, buf_in;
   logic [63:0]  cnt_ff, cnt_in;
   logic [63:0]  len_ff, len_in;
   logic [2:0]   idx_ff, idx_in;
   logic [255:0] chain_ff, chain_in;
   logic [255:0] digest_ff, digest_in;
   logic         done_ff, done_in;

   logic         absorb;
   logic [7:0]   ab_byte;
   logic [2:0]   ab_next;
   logic         core_start, core_done;
   logic [255:0] core_sum;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      chain_in   = chain_ff;
      digest_in  = digest_ff;
      done_in    = 1'b0;
      absorb     = 1'b0;
      ab_byte    = byte_data;
      ab_next    = H_IDLE;
      case (state_ff)
         H_IDLE: begin
            if (byte_valid) begin
               absorb = 1'b1;
            end else if (finish) begin
               len_in   = {cnt_ff[60:0], 3'b000};
               state_in = H_P80;
            end
         end
         H_COMP: begin
            if (core_done) begin
               chain_in = core_sum;
               state_in = ret_ff;
            end
         end
         H_P80: begin
            absorb  = 1'b1;
            ab_byte = PAD_BYTE;
            ab_next = H_PZ;
         end
         H_PZ: begin
            if (cnt_ff[5:0] == 6'd56) begin
               idx_in   = 3'd7;
               state_in = H_LEN;
            end else begin
               absorb  = 1'b1;
               ab_byte = 8'd0;
               ab_next = H_PZ;
            end
         end
         H_LEN: begin
            absorb  = 1'b1;
            ab_byte = len_ff[{idx_ff, 3'b000} +: 8];
            ab_next = (idx_ff == 3'd0) ? H_DONE : H_LEN;
            idx_in  = idx_ff - 3'd1;
         end
         H_DONE: begin
            // hold the digest, then drop back to the initial hash state
            digest_in = chain_ff;
            done_in   = 1'b1;
            chain_in  = SHA_IV;
            state_in  = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      core_start = 1'b0;
      if (absorb) begin
         buf_in = {buf_ff[503:0], ab_byte};
         cnt_in = cnt_ff + 64'd1;
         if (cnt_ff[5:0] == 6'd63) begin
            core_start = 1'b1;
            ret_in     = ab_next;
            state_in   = H_COMP;
         end else begin
            state_in = ab_next;
         end
      end
      if (state_ff == H_DONE) begin
         cnt_in = 64'd0;
      end
   end

   lsha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .block     (buf_in),
      .chain_in  (chain_ff),
      .done      (core_done),
      .chain_sum (core_sum)
   );

   always_ff @(posedge clock) begin
      buf_ff    <= buf_in;
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      digest_ff <= digest_in;
      ret_ff    <= ret_in;
      if (reset) begin
         state_ff <= H_IDLE;
         cnt_ff   <= 64'd0;
         chain_ff <= SHA_IV;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chain_ff <= chain_in;
         done_ff  <= done_in;
      end
   end

   assign byte_ready = (state_ff == H_IDLE);
   assign done       = done_ff;
   assign digest     = digest_ff;

endmodule
`default_nettype wire

// ===== hdl/lattice_set_hash_accumulator.sv =====
// Top level: lane memory, leaf and auxiliary hashers, expansion and root sequencer.
`default_nettype none
// Leaf bytes are taken whenever the leaf hasher is ready; every 64th byte stalls the input while
// the leaf hasher's compression unit runs its 64 rounds.
// A last byte triggers padding, then per expansion block 36 feed bytes, padding and
// compression, and a read-modify-write of its 16 lanes, skipping lanes past LANE_COUNT.
// A root request streams 2*LANE_COUNT bytes, low byte first per lane, into the auxiliary hasher.
// Reset is synchronous; a clearing pass then zeroes one lane a cycle until all lanes are zero.
module lattice_set_hash_accumulator #(
   parameter int LANE_COUNT       = 1024,
   parameter int EXPANSION_BLOCKS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic        req_subtract,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [63:0]      rsp_root_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_end_of_run
);
   import lsha_pkg::*;

   localparam int LANE_AW = $clog2(LANE_COUNT);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LFIN  = 4'd2;
   localparam logic [3:0] S_LWAIT = 4'd3;
   localparam logic [3:0] S_EFEED = 4'd4;
   localparam logic [3:0] S_EFIN  = 4'd5;
   localparam logic [3:0] S_EWAIT = 4'd6;
   localparam logic [3:0] S_ERD   = 4'd7;
   localparam logic [3:0] S_EWR   = 4'd8;
   localparam logic [3:0] S_ACK   = 4'd9;
   localparam logic [3:0] S_RRD   = 4'd10;
   localparam logic [3:0] S_RLO   = 4'd11;
   localparam logic [3:0] S_RHI   = 4'd12;
   localparam logic [3:0] S_RFIN  = 4'd13;
   localparam logic [3:0] S_RWAIT = 4'd14;
   localparam logic [3:0] S_ROUT  = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic [LANE_AW-1:0] lane_ff, lane_in;
   logic [7:0]         blk_ff, blk_in;
   logic [3:0]         sel_ff, sel_in;
   logic [5:0]         feed_ff, feed_in;
   logic [1:0]         widx_ff, widx_in;
   logic               sub_ff, sub_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [63:0]        rsp_word_ff, rsp_word_in;
   logic [1:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_end_ff, rsp_end_in;

   // lane memory, one synchronous port
   logic [15:0]        lane_mem [LANE_COUNT];
   logic [15:0]        rd_ff;
   logic               mem_we, mem_re;
   logic [LANE_AW-1:0] mem_addr;
   logic [15:0]        mem_wd;

   logic               leaf_valid, leaf_ready, leaf_finish, leaf_done;
   logic [255:0]       leaf_dig;
   logic               aux_valid, aux_ready, aux_finish, aux_done;
   logic [7:0]         aux_byte;
   logic [255:0]       aux_dig;

   logic               req_xfer, slot_free, last_blk, last_sel, in_range;
   logic [11:0]        exp_lane;
   logic [15:0]        exp_word;
   logic [63:0]        root_word;
   logic [4:0]         dig_n;

   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_blk  = (blk_ff == 8'(EXPANSION_BLOCKS - 1));
   assign last_sel  = (sel_ff == 4'd15);
   assign exp_lane  = {blk_ff, sel_ff};
   assign in_range  = ({1'b0, exp_lane} < 13'(LANE_COUNT));
   assign exp_word  = {aux_dig[8'd247 - {sel_ff, 4'd0} -: 8], aux_dig[8'd255 - {sel_ff, 4'd0} -: 8]};
   assign dig_n     = feed_ff[4:0];

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         root_word[8*b +: 8] = aux_dig[8'd255 - {widx_ff, 3'(b), 3'b000} -: 8];
      end
   end

   // ready only in idle; a leaf byte also needs the leaf hasher free
   assign req_ready  = (state_ff == S_IDLE) && (req_op || leaf_ready);
   assign leaf_valid = req_valid && (state_ff == S_IDLE) && !req_op;

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      blk_in       = blk_ff;
      sel_in       = sel_ff;
      feed_in      = feed_ff;
      widx_in      = widx_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_end_in   = rsp_end_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = lane_ff;
      mem_wd       = 16'd0;
      leaf_finish  = 1'b0;
      aux_valid    = 1'b0;
      aux_finish   = 1'b0;
      aux_byte     = 8'd0;
      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            if (lane_ff == LANE_AW'(LANE_COUNT - 1)) begin
               lane_in  = '0;
               state_in = S_IDLE;
            end else begin
               lane_in = lane_ff + LANE_AW'(1);
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               if (req_op) begin
                  lane_in  = '0;
                  state_in = S_RRD;
               end else begin
                  sub_in = req_subtract;
                  if (req_last) begin
                     state_in = S_LFIN;
                  end
               end
            end
         end
         S_LFIN: begin
            leaf_finish = 1'b1;
            if (leaf_ready) begin
               state_in = S_LWAIT;
            end
         end
         S_LWAIT: begin
            if (leaf_done) begin
               blk_in   = 8'd0;
               feed_in  = 6'd0;
               state_in = S_EFEED;
            end
         end
         S_EFEED: begin
            // seed bytes, then the block index as u32le
            aux_valid = 1'b1;
            if (feed_ff < 6'd32) begin
               aux_byte = leaf_dig[8'd255 - {dig_n, 3'b000} -: 8];
            end else if (feed_ff == 6'd32) begin
               aux_byte = blk_ff;
            end
            if (aux_ready) begin
               if (feed_ff == 6'd35) begin
                  state_in = S_EFIN;
               end else begin
                  feed_in = feed_ff + 6'd1;
               end
            end
         end
         S_EFIN: begin
            aux_finish = 1'b1;
            if (aux_ready) begin
               state_in = S_EWAIT;
            end
         end
         S_EWAIT: begin
            if (aux_done) begin
               sel_in   = 4'd0;
               state_in = S_ERD;
            end
         end
         S_ERD, S_EWR: begin
            mem_addr = exp_lane[LANE_AW-1:0];
            mem_wd   = sub_ff ? (rd_ff - exp_word) : (rd_ff + exp_word);
            if ((state_ff == S_ERD) && in_range) begin
               mem_re   = 1'b1;
               state_in = S_EWR;
            end else begin
               mem_we = (state_ff == S_EWR);
               if (!last_sel) begin
                  sel_in   = sel_ff + 4'd1;
                  state_in = S_ERD;
               end else if (last_blk) begin
                  state_in = S_ACK;
               end else begin
                  blk_in   = blk_ff + 8'd1;
                  feed_in  = 6'd0;
                  state_in = S_EFEED;
               end
            end
         end
         S_ACK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_word_in  = 64'd0;
               rsp_idx_in   = 2'd0;
               rsp_end_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RRD: begin
            mem_re   = 1'b1;
            state_in = S_RLO;
         end
         S_RLO: begin
            aux_valid = 1'b1;
            aux_byte  = rd_ff[7:0];
            if (aux_ready) begin
               state_in = S_RHI;
            end
         end
         S_RHI: begin
            aux_valid = 1'b1;
            aux_byte  = rd_ff[15:8];
            if (aux_ready) begin
               if (lane_ff == LANE_AW'(LANE_COUNT - 1)) begin
                  state_in = S_RFIN;
               end else begin
                  lane_in  = lane_ff + LANE_AW'(1);
                  state_in = S_RRD;
               end
            end
         end
         S_RFIN: begin
            aux_finish = 1'b1;
            if (aux_ready) begin
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            if (aux_done) begin
               widx_in  = 2'd0;
               state_in = S_ROUT;
            end
         end
         S_ROUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_word_in  = root_word;
               rsp_idx_in   = widx_ff;
               rsp_end_in   = (widx_ff == 2'd3);
               widx_in      = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lane_mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= lane_mem[mem_addr];
      end
   end

   lsha_hasher u_leaf (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (leaf_valid),
      .byte_data  (req_data_byte),
      .finish     (leaf_finish),
      .byte_ready (leaf_ready),
      .done       (leaf_done),
      .digest     (leaf_dig)
   );

   lsha_hasher u_aux (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (aux_valid),
      .byte_data  (aux_byte),
      .finish     (aux_finish),
      .byte_ready (aux_ready),
      .done       (aux_done),
      .digest     (aux_dig)
   );

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      sel_ff      <= sel_in;
      feed_ff     <= feed_in;
      widx_ff     <= widx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_end_ff  <= rsp_end_in;
      if (reset) begin
         state_ff     <= S_CLR;
         lane_ff      <= '0;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_root_word  = rsp_word_ff;
   assign rsp_word_index = rsp_idx_ff;
   assign rsp_end_of_run = rsp_end_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("lane write while idle");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("input ready outside idle");

   a_aux_done: assert property (@(posedge clock) disable iff (reset)
      aux_done |-> ((state_ff == S_EWAIT) || (state_ff == S_RWAIT)))
      else $error("unexpected auxiliary digest");

   a_leaf_done: assert property (@(posedge clock) disable iff (reset)
      leaf_done |-> (state_ff == S_LWAIT))
      else $error("unexpected leaf digest");

endmodule
`default_nettype wire
